FILE: sv/swbm_pkg.sv
// ----------------------------------------------------------------------------
// swbm_pkg: shared types and constants of the two-wire sensor bus master
// Sequence states, command and status codes, command bytes and the result
// record passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package swbm_pkg;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_RCLK     = 4'd1,
    S_START    = 4'd2,
    S_WCMD     = 4'd3,
    S_WCMD_ACK = 4'd4,
    S_WVAL     = 4'd5,
    S_WVAL_ACK = 4'd6,
    S_POLL     = 4'd7,
    S_RMSB     = 4'd8,
    S_RMSB_ACK = 4'd9,
    S_RLSB     = 4'd10,
    S_RLSB_ACK = 4'd11,
    S_RCRC     = 4'd12,
    S_RCRC_ACK = 4'd13,
    S_FIN      = 4'd14
  } state_t;

  // Command codes of the input item.
  localparam logic [2:0] OP_NONE         = 3'd0;
  localparam logic [2:0] OP_MEASURE_TEMP = 3'd1;
  localparam logic [2:0] OP_MEASURE_HUMI = 3'd2;
  localparam logic [2:0] OP_READ_STATUS  = 3'd3;
  localparam logic [2:0] OP_WRITE_STATUS = 3'd4;
  localparam logic [2:0] OP_SOFT_RESET   = 3'd5;

  // Bytes sent on the bus for each command.
  localparam logic [7:0] BYTE_MEASURE_TEMP = 8'h03;
  localparam logic [7:0] BYTE_MEASURE_HUMI = 8'h05;
  localparam logic [7:0] BYTE_READ_STATUS  = 8'h07;
  localparam logic [7:0] BYTE_WRITE_STATUS = 8'h06;
  localparam logic [7:0] BYTE_SOFT_RESET   = 8'h1e;

  // Finish status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NACK    = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_INTERVAL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_POLL_LIMIT    = 1'd1;
  localparam logic [15:0] POLL_INTERVAL_RESET = 16'd3000;
  localparam logic [7:0]  POLL_LIMIT_RESET    = 8'd240;

  localparam logic [3:0] RESET_CLOCKS = 4'd9;

  // Transmission start waveform, indexed by the dwell count (bit 0 first).
  localparam logic [7:0] START_SCK = 8'b1100_0110;
  localparam logic [7:0] START_EN  = 8'b0111_1100;

  typedef struct packed {
    logic [7:0]  checksum_byte;
    logic [15:0] result_value;
    logic [1:0]  status;
    logic        done_res;
    logic        busy_res;
    logic        data_drive_level;
    logic        data_drive_enable;
    logic        clock_line;
  } res_t;

  function automatic logic [7:0] command_byte(input logic [2:0] op);
    logic [7:0] b;
    unique case (op)
      OP_MEASURE_TEMP: b = BYTE_MEASURE_TEMP;
      OP_MEASURE_HUMI: b = BYTE_MEASURE_HUMI;
      OP_READ_STATUS:  b = BYTE_READ_STATUS;
      OP_WRITE_STATUS: b = BYTE_WRITE_STATUS;
      default:         b = BYTE_SOFT_RESET;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/sensor_two_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// sensor_two_wire_bus_master_top: two-wire sensor bus master
// One input transfer per bus tick carries the sampled DATA level and an
// optional command; one output transfer per tick gives the line levels and,
// on the finishing tick, the command result.
//
//   port group  | dir | carries
//   ------------+-----+-----------------------------------------------------
//   in_*        | in  | command, write_value, data_line (one bus tick)
//   out_*       | out | SCK/DATA drive, busy, done, status, result, checksum
//   cfg_*       | in  | poll_interval_ticks (0), poll_limit (1)
//
// Each tick passes an input register and the sequencer into the output
// register, one transfer per cycle sustained while out_tready stays high.
// The sequencer and a full input register advance together only when the
// output register is empty or being taken, so an out_tready stall holds both.
// Reset (rst_n, synchronous) empties both registers and returns to idle.
// ----------------------------------------------------------------------------
module sensor_two_wire_bus_master_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] command, [10:3] write_value, [11] data_line, [15:12] zero
  input  logic [15:0]                       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] clock_line, [1] data_drive_enable, [2] data_drive_level, [3] busy_res,
  // [4] done_res, [6:5] status, [22:7] result_value, [30:23] checksum_byte,
  // [31] zero
  output logic [31:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic [swbm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [swbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import swbm_pkg::*;

  logic        in_v_r;
  logic [2:0]  cmd_r;
  logic [7:0]  wval_r;
  logic        dline_r;
  logic        step;
  logic        out_v_r;
  res_t        res_r;
  res_t        res;
  logic [15:0] interval_r;
  logic [7:0]  limit_r;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tdata[2:0];
      wval_r  <= in_tdata[10:3];
      dline_r <= in_tdata[11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= POLL_INTERVAL_RESET;
      limit_r    <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLL_INTERVAL: interval_r <= cfg_wdata[15:0];
        REG_POLL_LIMIT:    limit_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  swbm_engine u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .step_en             (step),
    .command             (cmd_r),
    .write_value         (wval_r),
    .data_line           (dline_r),
    .poll_interval_ticks (interval_r),
    .poll_limit          (limit_r),
    .res                 (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

FILE: sv/swbm_engine.sv
// ----------------------------------------------------------------------------
// swbm_engine: bus sequencer of the two-wire sensor bus master
// Holds the sequence state and advances it by one tick per enabled cycle,
// producing the line levels and finish result of that tick.
// ----------------------------------------------------------------------------
module swbm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [2:0]        command,
  input  logic [7:0]        write_value,
  input  logic              data_line,
  input  logic [15:0]       poll_interval_ticks,
  input  logic [7:0]        poll_limit,
  output swbm_pkg::res_t    res
);
  import swbm_pkg::*;

  state_t      st_r, st_nxt, st_cur;
  logic [2:0]  op_r, op_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shf_r, shf_nxt;
  logic [15:0] dw_r, dw_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic [15:0] rw_r, rw_nxt;
  logic [7:0]  rc_r, rc_nxt;
  logic [1:0]  fs_r, fs_nxt;

  logic        take;
  logic [15:0] iv;
  logic [7:0]  lim;
  logic [7:0]  pc_inc;
  logic [3:0]  bit_inc;

  assign take = (st_r == S_IDLE) && (command >= OP_MEASURE_TEMP) &&
                (command <= OP_SOFT_RESET);
  assign iv  = (poll_interval_ticks == 16'd0) ? 16'd1 : poll_interval_ticks;
  assign lim = (poll_limit == 8'd0) ? 8'd1 : poll_limit;

  always_comb begin
    // A new command restarts all sequence state before this tick is worked.
    st_cur  = st_r;
    op_nxt  = op_r;
    bit_nxt = bit_r;
    shf_nxt = shf_r;
    dw_nxt  = dw_r;
    pc_nxt  = pc_r;
    rw_nxt  = rw_r;
    rc_nxt  = rc_r;
    fs_nxt  = fs_r;
    if (take) begin
      op_nxt  = command;
      rw_nxt  = (command == OP_WRITE_STATUS) ? {8'd0, write_value} : 16'd0;
      rc_nxt  = 8'd0;
      fs_nxt  = STAT_OK;
      bit_nxt = 4'd0;
      dw_nxt  = 16'd0;
      pc_nxt  = 8'd0;
      shf_nxt = 8'd0;
      st_cur  = (command == OP_SOFT_RESET) ? S_RCLK : S_START;
    end
    st_nxt  = st_cur;
    pc_inc  = pc_nxt + 8'd1;
    bit_inc = bit_nxt + 4'd1;

    res = '0;
    res.busy_res = 1'b1;

    unique case (st_cur)
      S_IDLE: begin
        res.busy_res = 1'b0;
      end
      S_RCLK: begin
        res.clock_line = (dw_nxt < 16'd3);
        if (dw_nxt >= 16'd5) begin
          dw_nxt  = 16'd0;
          bit_nxt = bit_inc;
          if (bit_inc >= RESET_CLOCKS) begin
            bit_nxt = 4'd0;
            st_nxt  = S_START;
          end
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_START: begin
        res.clock_line        = START_SCK[dw_nxt[2:0]];
        res.data_drive_enable = START_EN[dw_nxt[2:0]];
        if (dw_nxt >= 16'd7) begin
          dw_nxt  = 16'd0;
          bit_nxt = 4'd0;
          shf_nxt = command_byte(op_nxt);
          st_nxt  = S_WCMD;
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_WCMD, S_WVAL: begin
        res.data_drive_enable = 1'b1;
        res.data_drive_level  = shf_nxt[7];
        res.clock_line        = (dw_nxt < 16'd3);
        if (dw_nxt >= 16'd5) begin
          dw_nxt  = 16'd0;
          shf_nxt = {shf_nxt[6:0], 1'b0};
          bit_nxt = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_nxt = 4'd0;
            st_nxt  = (st_cur == S_WCMD) ? S_WCMD_ACK : S_WVAL_ACK;
          end
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_WCMD_ACK, S_WVAL_ACK: begin
        res.clock_line = 1'b1;
        if (dw_nxt >= 16'd3) begin
          dw_nxt = 16'd0;
          if (data_line) begin
            fs_nxt = STAT_NACK;
            rw_nxt = 16'd0;
            rc_nxt = 8'd0;
            st_nxt = S_FIN;
          end else if (st_cur == S_WVAL_ACK) begin
            fs_nxt = STAT_OK;
            st_nxt = S_FIN;
          end else begin
            bit_nxt = 4'd0;
            if (op_nxt == OP_MEASURE_TEMP || op_nxt == OP_MEASURE_HUMI) begin
              pc_nxt = 8'd0;
              st_nxt = S_POLL;
            end else if (op_nxt == OP_READ_STATUS) begin
              st_nxt = S_RLSB;
            end else if (op_nxt == OP_WRITE_STATUS) begin
              shf_nxt = rw_nxt[7:0];
              st_nxt  = S_WVAL;
            end else begin
              fs_nxt = STAT_OK;
              st_nxt = S_FIN;
            end
          end
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_POLL: begin
        if ({1'b0, dw_nxt} + 17'd1 >= {1'b0, iv}) begin
          dw_nxt = 16'd0;
          if (!data_line) begin
            bit_nxt = 4'd0;
            st_nxt  = S_RMSB;
          end else begin
            pc_nxt = pc_inc;
            if (pc_inc >= lim) begin
              fs_nxt = STAT_TIMEOUT;
              rw_nxt = 16'd0;
              rc_nxt = 8'd0;
              st_nxt = S_FIN;
            end
          end
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_RMSB, S_RLSB, S_RCRC: begin
        res.clock_line = (dw_nxt == 16'd0);
        if (dw_nxt == 16'd0) begin
          shf_nxt = {shf_nxt[6:0], data_line};
          dw_nxt  = 16'd1;
        end else begin
          dw_nxt  = 16'd0;
          bit_nxt = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_nxt = 4'd0;
            st_nxt  = (st_cur == S_RMSB) ? S_RMSB_ACK :
                      (st_cur == S_RLSB) ? S_RLSB_ACK : S_RCRC_ACK;
          end
        end
      end
      S_RMSB_ACK, S_RLSB_ACK, S_RCRC_ACK: begin
        res.data_drive_enable = 1'b1;
        // The checksum is not acknowledged: DATA is held high instead.
        res.data_drive_level  = (st_cur == S_RCRC_ACK);
        res.clock_line        = (dw_nxt < 16'd3);
        if (dw_nxt >= 16'd3) begin
          dw_nxt = 16'd0;
          if (st_cur == S_RMSB_ACK) begin
            rw_nxt = {shf_nxt, 8'd0};
            st_nxt = S_RLSB;
          end else if (st_cur == S_RLSB_ACK) begin
            rw_nxt = rw_nxt | {8'd0, shf_nxt};
            st_nxt = S_RCRC;
          end else begin
            rc_nxt = shf_nxt;
            fs_nxt = STAT_OK;
            st_nxt = S_FIN;
          end
        end else begin
          dw_nxt = dw_nxt + 16'd1;
        end
      end
      S_FIN: begin
        res.busy_res      = 1'b0;
        res.done_res      = 1'b1;
        res.status        = fs_nxt;
        res.result_value  = rw_nxt;
        res.checksum_byte = rc_nxt;
        st_nxt            = S_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        st_nxt       = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      op_r  <= OP_NONE;
      bit_r <= 4'd0;
      shf_r <= 8'd0;
      dw_r  <= 16'd0;
      pc_r  <= 8'd0;
      rw_r  <= 16'd0;
      rc_r  <= 8'd0;
      fs_r  <= STAT_OK;
    end else if (step_en) begin
      st_r  <= st_nxt;
      op_r  <= op_nxt;
      bit_r <= bit_nxt;
      shf_r <= shf_nxt;
      dw_r  <= dw_nxt;
      pc_r  <= pc_nxt;
      rw_r  <= rw_nxt;
      rc_r  <= rc_nxt;
      fs_r  <= fs_nxt;
    end
  end

endmodule
